### sv/assert_macros.svh
// Assertion macros for the angular dark pixel histogram RTL.
// No dependencies; included by adph_ctrl, which carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ADPH_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define ADPH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### sv/adph_pkg.sv
// Package for the angular dark pixel histogram: FSM state, command/status
// structs, register indices and the CORDIC arctangent table. No dependencies.
package adph_pkg;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int COUNT_W      = 25;
  localparam int ZW           = 16;
  localparam int STEP_W       = 4;
  localparam int CORDIC_LAST  = 13;
  localparam int DSTEP_W      = 5;
  localparam int DIV_LAST     = 16;
  localparam int BIN_PORT_W   = 6;
  localparam int FRAC_W       = 16;
  localparam int QUARTER_MAX  = 16383;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CORDIC = 8'b0000_0010,
    S_BIN    = 8'b0000_0100,
    S_INC    = 8'b0000_1000,
    S_ORD    = 8'b0001_0000,
    S_OLOAD  = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic accept;
    logic cordic_step;
    logic bin_read;
    logic bin_update;
    logic out_read;
    logic div_load;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic frame_end;
    logic div_done;
    logic last_bin;
  } stat_t;

  // atan(2^-i) in units of 2^-16 turn
  function automatic logic signed [ZW-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      4'd0:    r = 16'sd8192;
      4'd1:    r = 16'sd4836;
      4'd2:    r = 16'sd2555;
      4'd3:    r = 16'sd1297;
      4'd4:    r = 16'sd651;
      4'd5:    r = 16'sd326;
      4'd6:    r = 16'sd163;
      4'd7:    r = 16'sd81;
      4'd8:    r = 16'sd41;
      4'd9:    r = 16'sd20;
      4'd10:   r = 16'sd10;
      4'd11:   r = 16'sd5;
      4'd12:   r = 16'sd3;
      4'd13:   r = 16'sd1;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

endpackage

### sv/angular_dark_pixel_histogram.sv
// Top level of the angular dark pixel histogram.
// Depends on adph_pkg, adph_ctrl and adph_dp.
//
// One pixel is taken when start is high and busy low; each pixel then holds
// busy through the one-iteration-a-cycle CORDIC angle unit and the
// read-modify-write of the bin memory. After the last pixel of a frame the
// block emits NUM_BINS results in turn (bin read, divider load, restoring
// divide, emit), each on out_* for a single cycle marked by out_valid; the
// receiver cannot stall them. The histogram is cleared by valid bits, with no
// sweep after reset.
module angular_dark_pixel_histogram
  import adph_pkg::*;
#(
  parameter int NUM_BINS   = 36,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [7:0]            in_pixel_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [BIN_PORT_W-1:0] out_bin_index,
  output logic [FRAC_W-1:0]     out_fraction,
  output logic                  out_empty_frame,
  output logic                  out_last
);

  cmd_t  cmd;
  stat_t st;

  adph_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .st    (st)
  );

  adph_dp #(
    .NUM_BINS   (NUM_BINS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .pixel_value     (in_pixel_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_bin_index   (out_bin_index),
    .out_fraction    (out_fraction),
    .out_empty_frame (out_empty_frame),
    .out_last        (out_last)
  );

endmodule

### sv/adph_ctrl.sv
// Controller FSM for the angular dark pixel histogram.
// Depends on adph_pkg and assert_macros.svh; drives adph_dp by cmd_t.
`include "assert_macros.svh"
module adph_ctrl
  import adph_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  output cmd_t  cmd,
  input  stat_t st
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CORDIC;
        end
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (st.cordic_done) state_nxt = S_BIN;
      end
      S_BIN: begin
        cmd.bin_read = 1'b1;
        state_nxt    = S_INC;
      end
      S_INC: begin
        cmd.bin_update = 1'b1;
        state_nxt      = st.frame_end ? S_ORD : S_IDLE;
      end
      S_ORD: begin
        cmd.out_read = 1'b1;
        state_nxt    = S_OLOAD;
      end
      S_OLOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = st.last_bin ? S_IDLE : S_ORD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  `ADPH_ASSERT_NEXT(a_accept_busy, clk, rst_n, cmd.accept, busy, "no busy after transfer")
  `ADPH_ASSERT_IMPL(a_emit_after_div, clk, rst_n, state_r == S_EMIT, $past(state_r) == S_DIV, "emit without divide")
  `ADPH_ASSERT_NEXT(a_inc_idle, clk, rst_n, state_r == S_INC && !st.frame_end, state_r == S_IDLE, "pixel did not finish")

endmodule

### sv/adph_dp.sv
// Datapath: config registers, pixel position, CORDIC angle unit, bin memory
// and restoring divider. Depends on adph_pkg; commanded by adph_ctrl.
module adph_dp
  import adph_pkg::*;
#(
  parameter int NUM_BINS   = 36,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 st,
  input  logic [7:0]            pixel_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [BIN_PORT_W-1:0] out_bin_index,
  output logic [FRAC_W-1:0]     out_fraction,
  output logic                  out_empty_frame,
  output logic                  out_last
);

  localparam int BW   = $clog2(NUM_BINS);
  localparam int CB   = COORD_BITS;
  localparam int DIMW = CB + 1;
  localparam int CW   = CB + 19;
  localparam int TOP  = 1 << CB;
  localparam int PW   = 23;

  // configuration
  logic [CFG_DATA_W-1:0] w_r, h_r;
  logic [11:0]           cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r  <= 13'd640;
      h_r  <= 13'd480;
      cx_r <= 12'd320;
      cy_r <= 12'd240;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  w_r  <= cfg_data;
        REG_IMAGE_HEIGHT: h_r  <= cfg_data;
        REG_CENTER_X:     cx_r <= cfg_data[11:0];
        REG_CENTER_Y:     cy_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  logic [DIMW-1:0] wc, hc;
  always_comb begin
    if (w_r == '0)              wc = DIMW'(1);
    else if (w_r > 13'(TOP))    wc = DIMW'(TOP);
    else                        wc = w_r[DIMW-1:0];
    if (h_r == '0)              hc = DIMW'(1);
    else if (h_r > 13'(TOP))    hc = DIMW'(TOP);
    else                        hc = h_r[DIMW-1:0];
  end

  // pixel position
  logic [CB-1:0]   col_r, row_r;
  logic [DIMW-1:0] col_inc, row_inc;
  logic            row_end, frame_end;

  assign col_inc   = {1'b0, col_r} + DIMW'(1);
  assign row_inc   = {1'b0, row_r} + DIMW'(1);
  assign row_end   = !(col_inc < wc);
  assign frame_end = row_end && !(row_inc < hc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.accept) begin
      if (!row_end) begin
        col_r <= col_inc[CB-1:0];
      end else begin
        col_r <= '0;
        row_r <= frame_end ? '0 : row_inc[CB-1:0];
      end
    end
  end

  // quadrant fold
  logic signed [DIMW-1:0] dx, dy, u0, v0;
  logic [1:0]             quad;
  assign dx = $signed({1'b0, col_r}) - $signed({1'b0, cx_r[CB-1:0]});
  assign dy = $signed({1'b0, cy_r[CB-1:0]}) - $signed({1'b0, row_r});

  always_comb begin
    if (dx > 0 && dy >= 0) begin
      quad = 2'd0; u0 = dx;  v0 = dy;
    end else if (dx <= 0 && dy > 0) begin
      quad = 2'd1; u0 = dy;  v0 = -dx;
    end else if (dx < 0 && dy <= 0) begin
      quad = 2'd2; u0 = -dx; v0 = -dy;
    end else begin
      quad = 2'd3; u0 = -dy; v0 = dx;
    end
  end

  // CORDIC vectoring, one iteration a cycle
  logic signed [CW-1:0] u_r, v_r, us, vs;
  logic signed [ZW-1:0] z_r;
  logic [1:0]           quad_r;
  logic [STEP_W-1:0]    step_r;
  logic                 count_r, fend_r;

  assign us = u_r >>> step_r;
  assign vs = v_r >>> step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 1'b0;
      fend_r  <= 1'b0;
    end else if (cmd.accept) begin
      count_r <= (pixel_value == 8'd0) && !(dx == 0 && dy == 0);
      fend_r  <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      u_r    <= CW'(u0) <<< 16;
      v_r    <= CW'(v0) <<< 16;
      z_r    <= '0;
      quad_r <= quad;
      step_r <= '0;
    end else if (cmd.cordic_step) begin
      step_r <= step_r + STEP_W'(1);
      if (!v_r[CW-1]) begin
        u_r <= u_r + vs;
        v_r <= v_r - us;
        z_r <= z_r + atan_lut(step_r);
      end else begin
        u_r <= u_r - vs;
        v_r <= v_r + us;
        z_r <= z_r - atan_lut(step_r);
      end
    end
  end

  // angle to bin
  logic [13:0]   zc;
  logic [15:0]   ang;
  logic [PW-1:0] prod;
  logic [6:0]    bin_raw;
  logic [BW-1:0] bin_c, bin_r, k_r, rd_addr;

  always_comb begin
    if (z_r < 0)                       zc = '0;
    else if (z_r > ZW'(QUARTER_MAX))   zc = 14'(QUARTER_MAX);
    else                               zc = z_r[13:0];
  end
  assign ang     = {quad_r, zc};
  assign prod    = PW'(ang) * PW'(NUM_BINS);
  assign bin_raw = prod[PW-1:16];
  assign bin_c   = (bin_raw > 7'(NUM_BINS - 1)) ? BW'(NUM_BINS - 1) : bin_raw[BW-1:0];
  assign rd_addr = cmd.bin_read ? bin_c : k_r;

  // bin memory; a cleared entry reads as zero through its valid bit
  logic [COUNT_W-1:0]  mem [NUM_BINS];
  logic [NUM_BINS-1:0] vld_r;
  logic [COUNT_W-1:0]  rd_data_r, cnt_cur, total_r;
  logic                rd_vld_r;
  logic                last_k;

  assign cnt_cur = rd_vld_r ? rd_data_r : '0;
  assign last_k  = (k_r == BW'(NUM_BINS - 1));

  always_ff @(posedge clk) begin
    if (cmd.bin_read || cmd.out_read) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
    if (cmd.bin_read) bin_r <= bin_c;
    if (cmd.bin_update && count_r) mem[bin_r] <= cnt_cur + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      total_r <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.bin_update && count_r) begin
        vld_r[bin_r] <= 1'b1;
        total_r      <= total_r + COUNT_W'(1);
      end
      if (cmd.emit) begin
        k_r <= last_k ? '0 : k_r + BW'(1);
        if (last_k) begin
          vld_r   <= '0;
          total_r <= '0;
        end
      end
    end
  end

  // restoring divider: count * 2^16 / total, 17 quotient bits
  logic [COUNT_W:0]   rem_r, diff;
  logic [16:0]        quo_r;
  logic [DSTEP_W-1:0] dstep_r;
  logic               ge;

  assign ge   = rem_r >= {1'b0, total_r};
  assign diff = ge ? rem_r - {1'b0, total_r} : rem_r;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r   <= {1'b0, cnt_cur};
      quo_r   <= '0;
      dstep_r <= '0;
    end else if (cmd.div_step) begin
      rem_r   <= {diff[COUNT_W-1:0], 1'b0};
      quo_r   <= {quo_r[15:0], ge};
      dstep_r <= dstep_r + DSTEP_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_bin_index   <= BIN_PORT_W'(k_r);
      out_empty_frame <= (total_r == '0);
      out_last        <= last_k;
      if (total_r == '0)  out_fraction <= '0;
      else if (quo_r[16]) out_fraction <= '1;
      else                out_fraction <= quo_r[15:0];
    end
  end

  assign st.cordic_done = (step_r == STEP_W'(CORDIC_LAST));
  assign st.frame_end   = fend_r;
  assign st.div_done    = (dstep_r == DSTEP_W'(DIV_LAST));
  assign st.last_bin    = last_k;

endmodule
